[rtl/core/ipr_pkg.sv]
// Shared types and constants for the icon plane run-length decoder.
package ipr_pkg;

  // Plane size limits and field widths.
  localparam int MAX_PLANE_BYTES = 4096;
  localparam int PLANE_W         = 13;
  localparam int PLANE_SUM_W     = PLANE_W + 1;
  localparam int BYTE_W          = 8;
  localparam int PLANE_IDX_W     = 2;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_IDX_W       = 1;

  // Control byte decoding.
  localparam logic [BYTE_W-1:0] LITERAL_MAX  = 8'h7f;
  localparam logic [BYTE_W-1:0] REPEAT_BIAS  = 8'd125;

  // Register reset values.
  localparam logic [PLANE_W-1:0]     PLANE_BYTES_RST = 13'd1024;
  localparam logic [PLANE_IDX_W-1:0] PLANE_COUNT_RST = 2'd3;

  // Result queue depth.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_BYTES = 1'b0,
    CFG_PLANE_COUNT = 1'b1
  } cfg_reg_t;

  // Decoder phase.
  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_REP  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // One decoded result item.
  typedef struct packed {
    logic [BYTE_W-1:0]      pixel_value;
    logic [BYTE_W-1:0]      run_length;
    logic [PLANE_IDX_W-1:0] plane_index;
    logic                   plane_done;
    logic                   icon_done;
    logic                   overrun;
  } result_t;

endpackage

[rtl/core/ipr_front.sv]
// Front end: classifies compressed bytes, tracks runs and plane fill, forms results.
module ipr_front
  import ipr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [BYTE_W-1:0]     code_byte,
  output logic                  res_valid,
  output result_t               res
);

  phase_t                 phase_r, phase_nxt;
  logic [BYTE_W-1:0]      lit_left_r, lit_left_nxt;
  logic [BYTE_W-1:0]      rep_cnt_r, rep_cnt_nxt;
  logic [PLANE_W-1:0]     filled_r, filled_nxt;
  logic [PLANE_IDX_W-1:0] plane_r, plane_nxt;
  logic [PLANE_W-1:0]     plane_bytes_r, plane_bytes_nxt;
  logic [PLANE_IDX_W-1:0] plane_count_r, plane_count_nxt;

  logic [PLANE_W-1:0]     size;
  logic [PLANE_IDX_W-1:0] planes;
  logic [PLANE_W-1:0]     space;
  logic [PLANE_W-1:0]     rep_len;
  logic                   rep_clip;
  logic [PLANE_W-1:0]     add_len;
  logic [PLANE_SUM_W-1:0] fill_sum;
  logic                   pdone;
  logic                   last_plane;
  logic [BYTE_W-1:0]      lit_dec;
  logic [PLANE_W-1:0]     filled_upd;
  logic [PLANE_IDX_W-1:0] plane_upd;

  // Effective plane size and plane count, with out-of-range values folded in.
  always_comb begin
    if (plane_bytes_r == '0) begin
      size = PLANE_W'(1);
    end else if (plane_bytes_r > PLANE_W'(MAX_PLANE_BYTES)) begin
      size = PLANE_W'(MAX_PLANE_BYTES);
    end else begin
      size = plane_bytes_r;
    end
    planes = (plane_count_r == '0) ? PLANE_IDX_W'(1) : plane_count_r;
  end

  // Repeat clipping against the space left in the plane, and the fill update.
  always_comb begin
    space      = size - filled_r;
    rep_clip   = {{(PLANE_W-BYTE_W){1'b0}}, rep_cnt_r} > space;
    rep_len    = rep_clip ? space : {{(PLANE_W-BYTE_W){1'b0}}, rep_cnt_r};
    add_len    = (phase_r == PH_LIT) ? PLANE_W'(1) : rep_len;
    fill_sum   = {1'b0, filled_r} + {1'b0, add_len};
    pdone      = fill_sum >= {1'b0, size};
    last_plane = ({1'b0, plane_r} + 3'd1) >= {1'b0, planes};
    lit_dec    = (lit_left_r != '0) ? lit_left_r - 8'd1 : '0;
    filled_upd = pdone ? '0 : fill_sum[PLANE_W-1:0];
    if (!pdone) begin
      plane_upd = plane_r;
    end else if (last_plane) begin
      plane_upd = '0;
    end else begin
      plane_upd = plane_r + 2'd1;
    end
  end

  // Next state and result for the accepted item.
  always_comb begin
    phase_nxt       = phase_r;
    lit_left_nxt    = lit_left_r;
    rep_cnt_nxt     = rep_cnt_r;
    filled_nxt      = filled_r;
    plane_nxt       = plane_r;
    plane_bytes_nxt = plane_bytes_r;
    plane_count_nxt = plane_count_r;
    res_valid       = 1'b0;
    res.pixel_value = code_byte;
    res.run_length  = 8'd1;
    res.plane_index = plane_r;
    res.plane_done  = pdone;
    res.icon_done   = pdone && last_plane;
    res.overrun     = 1'b0;

    if (accept) begin
      unique case (phase_r)
        PH_CTRL: begin
          if (code_byte <= LITERAL_MAX) begin
            lit_left_nxt = code_byte + 8'd1;
            phase_nxt    = PH_LIT;
          end else begin
            rep_cnt_nxt = code_byte - REPEAT_BIAS;
            phase_nxt   = PH_REP;
          end
        end
        PH_SKIP: begin
          lit_left_nxt = lit_dec;
          if (lit_dec == '0) begin
            phase_nxt = PH_CTRL;
          end
        end
        PH_LIT: begin
          res_valid    = 1'b1;
          lit_left_nxt = lit_dec;
          filled_nxt   = filled_upd;
          plane_nxt    = plane_upd;
          if (lit_dec == '0) begin
            phase_nxt = PH_CTRL;
          end else if (pdone) begin
            res.overrun = 1'b1;
            phase_nxt   = PH_SKIP;
          end
        end
        PH_REP: begin
          res_valid      = 1'b1;
          res.run_length = rep_len[BYTE_W-1:0];
          res.overrun    = rep_clip;
          filled_nxt     = filled_upd;
          plane_nxt      = plane_upd;
          rep_cnt_nxt    = '0;
          phase_nxt      = PH_CTRL;
        end
        default: begin
          phase_nxt = PH_CTRL;
        end
      endcase
    end

    // A register write also restarts decoding.
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PLANE_BYTES: plane_bytes_nxt = cfg_data[PLANE_W-1:0];
        CFG_PLANE_COUNT: plane_count_nxt = cfg_data[PLANE_IDX_W-1:0];
        default: ;
      endcase
      phase_nxt    = PH_CTRL;
      lit_left_nxt = '0;
      rep_cnt_nxt  = '0;
      filled_nxt   = '0;
      plane_nxt    = '0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_CTRL;
      lit_left_r    <= '0;
      rep_cnt_r     <= '0;
      filled_r      <= '0;
      plane_r       <= '0;
      plane_bytes_r <= PLANE_BYTES_RST;
      plane_count_r <= PLANE_COUNT_RST;
    end else begin
      phase_r       <= phase_nxt;
      lit_left_r    <= lit_left_nxt;
      rep_cnt_r     <= rep_cnt_nxt;
      filled_r      <= filled_nxt;
      plane_r       <= plane_nxt;
      plane_bytes_r <= plane_bytes_nxt;
      plane_count_r <= plane_count_nxt;
    end
  end

endmodule

[rtl/core/ipr_queue.sv]
// Back end: short result queue that decouples the decoder from the consumer.
module ipr_queue
  import ipr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output logic    full,
  output logic    empty,
  output result_t rd_data
);

  result_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_wr;
  logic                do_rd;

  // Status flags and handshake qualification.
  always_comb begin
    full  = count_r == QCNT_W'(QUEUE_DEPTH);
    empty = count_r == '0;
    do_wr = wr_en && !full;
    do_rd = rd_en && !empty;
  end

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage for waiting items.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = entries[rd_ptr_r];

endmodule

[rtl/core/icon_plane_rle_decoder_core.sv]
// Icon plane run-length decoder: one compressed byte per cycle, results through a queue.
// Results enter the queue as their bytes are accepted; the oldest one drives the ports.
// The decoder takes one byte per cycle; decode and plane accounting are combinational.
// Input stalls only while the four-entry result queue is full.
// Reset (synchronous, rst_n low) empties the queue, restores plane_bytes 1024 and
// plane_count 3, and sets the decoder to expect a control byte.
module icon_plane_rle_decoder_core
  import ipr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [BYTE_W-1:0]      in_code_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [BYTE_W-1:0]      out_pixel_value,
  output logic [BYTE_W-1:0]      out_run_length,
  output logic [PLANE_IDX_W-1:0] out_plane_index,
  output logic                   out_plane_done,
  output logic                   out_icon_done,
  output logic                   out_overrun
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t head;

  // An input item is taken whenever the queue has room.
  assign accept = push && !full;

  ipr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .code_byte (in_code_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ipr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .full    (full),
    .empty   (empty),
    .rd_data (head)
  );

  // Oldest waiting result onto the output ports.
  assign out_pixel_value = head.pixel_value;
  assign out_run_length  = head.run_length;
  assign out_plane_index = head.plane_index;
  assign out_plane_done  = head.plane_done;
  assign out_icon_done   = head.icon_done;
  assign out_overrun     = head.overrun;

endmodule

[tb/icon_plane_rle_decoder_core_tb.sv]
// Self-checking testbench for the icon plane run-length decoder core.
module icon_plane_rle_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipr_pkg::*;

  localparam int RANDOM_ITEMS   = 750;
  localparam int STEADY_FIRST   = 350;
  localparam int STEADY_LAST    = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;
  localparam int IDLE_PERCENT   = 21;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  // One row of the directed table: a byte item or a register write.
  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    result_t               want;
  } stim_row_t;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index    = CFG_PLANE_BYTES;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   push         = 1'b0;
  logic                   full;
  logic [BYTE_W-1:0]      in_code_byte = '0;
  logic                   empty;
  logic                   pop          = 1'b0;
  logic [BYTE_W-1:0]      out_pixel_value;
  logic [BYTE_W-1:0]      out_run_length;
  logic [PLANE_IDX_W-1:0] out_plane_index;
  logic                   out_plane_done;
  logic                   out_icon_done;
  logic                   out_overrun;

  // Decoder state mirrored by the testbench.
  logic [PLANE_W-1:0]     plane_bytes_cfg;
  logic [1:0]             plane_count_cfg;
  phase_t                 dec_phase;
  logic [7:0]             lit_left;
  logic [7:0]             rep_left;
  int                     filled;
  logic [PLANE_IDX_W-1:0] plane_now;

  result_t pending_pixels[$];
  int      mismatch_count = 0;
  int      items_sent     = 0;
  int      quiet_cycles   = 0;
  bit      steady         = 1'b0;

  icon_plane_rle_decoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_code_byte    (in_code_byte),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_value (out_pixel_value),
    .out_run_length  (out_run_length),
    .out_plane_index (out_plane_index),
    .out_plane_done  (out_plane_done),
    .out_icon_done   (out_icon_done),
    .out_overrun     (out_overrun)
  );

  always #5 clk = ~clk;

  // Return the decoder to the start of a stream.
  function automatic void restart_decoder();
    dec_phase = PH_CTRL;
    lit_left  = '0;
    rep_left  = '0;
    filled    = 0;
    plane_now = '0;
  endfunction

  // Effective plane size after clamping to the supported range.
  function automatic int plane_size();
    int pb;
    pb = int'(plane_bytes_cfg);
    if (pb == 0) return 1;
    if (pb > MAX_PLANE_BYTES) return MAX_PLANE_BYTES;
    return pb;
  endfunction

  // Count decoded bytes against the plane and advance the plane at its end.
  function automatic void add_bytes(input int len, output bit pdone, output bit idone);
    int planes;
    planes = (plane_count_cfg == 2'd0) ? 1 : int'(plane_count_cfg);
    filled += len;
    pdone = 1'b0;
    idone = 1'b0;
    if (filled >= plane_size()) begin
      filled = 0;
      pdone  = 1'b1;
      if (int'(plane_now) + 1 >= planes) begin
        plane_now = '0;
        idone     = 1'b1;
      end else begin
        plane_now = plane_now + 2'd1;
      end
    end
  endfunction

  // Work out the result, if any, that one code byte causes.
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    int len;
    bit over;
    bit pdone;
    bit idone;
    bit made;
    r    = '0;
    made = 1'b0;
    len  = 0;
    over = 1'b0;
    case (dec_phase)
      PH_CTRL: begin
        if (b <= LITERAL_MAX) begin
          lit_left  = b + 8'd1;
          dec_phase = PH_LIT;
        end else begin
          rep_left  = b - REPEAT_BIAS;
          dec_phase = PH_REP;
        end
      end
      PH_SKIP: begin
        if (lit_left != 8'd0) lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) dec_phase = PH_CTRL;
      end
      PH_LIT: begin
        if (lit_left != 8'd0) lit_left = lit_left - 8'd1;
        len  = 1;
        made = 1'b1;
      end
      default: begin
        len = int'(rep_left);
        if (len > plane_size() - filled) begin
          len  = plane_size() - filled;
          over = 1'b1;
        end
        rep_left = '0;
        made     = 1'b1;
      end
    endcase
    if (made) begin
      r.plane_index = plane_now;
      add_bytes(len, pdone, idone);
      if (dec_phase == PH_LIT) begin
        if (lit_left == 8'd0) begin
          dec_phase = PH_CTRL;
        end else if (pdone) begin
          over      = 1'b1;
          dec_phase = PH_SKIP;
        end
      end else begin
        dec_phase = PH_CTRL;
      end
      r.pixel_value = b;
      r.run_length  = len[7:0];
      r.plane_done  = pdone;
      r.icon_done   = idone;
      r.overrun     = over;
    end
    return made;
  endfunction

  function automatic result_t mk_res(input logic [7:0] pv, input logic [7:0] rl,
                                     input logic [1:0] pi, input logic pd,
                                     input logic id, input logic ov);
    result_t r;
    r.pixel_value = pv;
    r.run_length  = rl;
    r.plane_index = pi;
    r.plane_done  = pd;
    r.icon_done   = id;
    r.overrun     = ov;
    return r;
  endfunction

  function automatic stim_row_t b_row(input logic [7:0] b);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_BYTE;
    row.data = {5'd0, b};
    return row;
  endfunction

  function automatic stim_row_t w_row(input logic [7:0] b, input result_t want);
    stim_row_t row;
    row       = b_row(b);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t c_row(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_sel = sel;
    row.data    = d;
    return row;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Lower push and wait until every expected result has come out.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register while the decoder is idle; a write restarts decoding.
  task automatic cfg_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_PLANE_BYTES) plane_bytes_cfg = d;
    else plane_count_cfg = d[1:0];
    restart_decoder();
    @(posedge clk);
  endtask

  // Offer one code byte, with an occasional gap, and predict what it causes.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    result_t predicted;
    steady = (items_sent >= STEADY_FIRST) && (items_sent < STEADY_LAST);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_code_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (decode_byte(b, predicted)) pending_pixels.push_back(typed ? want : predicted);
  endtask

  // Result side: check each accepted item and stall at random.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected result", int'(out_pixel_value), -1);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_value !== want.pixel_value)
          flag_mismatch("pixel_value", int'(out_pixel_value), int'(want.pixel_value));
        if (out_run_length !== want.run_length)
          flag_mismatch("run_length", int'(out_run_length), int'(want.run_length));
        if (out_plane_index !== want.plane_index)
          flag_mismatch("plane_index", int'(out_plane_index), int'(want.plane_index));
        if (out_plane_done !== want.plane_done)
          flag_mismatch("plane_done", int'(out_plane_done), int'(want.plane_done));
        if (out_icon_done !== want.icon_done)
          flag_mismatch("icon_done", int'(out_icon_done), int'(want.icon_done));
        if (out_overrun !== want.overrun)
          flag_mismatch("overrun", int'(out_overrun), int'(want.overrun));
      end
    end
    pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog: end the run when no item moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t             rows[$];
    int                    sel;
    int                    n;
    int                    phase_len;
    int                    phase_start;
    int                    random_start;
    logic [CFG_DATA_W-1:0] size_val;
    logic [CFG_DATA_W-1:0] count_val;
    bit                    long_runs;

    plane_bytes_cfg = PLANE_BYTES_RST;
    plane_count_cfg = PLANE_COUNT_RST;
    restart_decoder();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset defaults, run extremes, clipping and clamped registers.
    rows.push_back(b_row(8'h00));
    rows.push_back(w_row(8'hff, mk_res(8'hff, 8'd1, 2'd0, 1'b0, 1'b0, 1'b0)));
    rows.push_back(b_row(8'hff));
    rows.push_back(w_row(8'h00, mk_res(8'h00, 8'd130, 2'd0, 1'b0, 1'b0, 1'b0)));
    rows.push_back(b_row(8'h80));
    rows.push_back(b_row(8'ha5));
    rows.push_back(c_row(CFG_PLANE_BYTES, 13'd4));
    rows.push_back(c_row(CFG_PLANE_COUNT, 13'd1));
    // A literal run cut at the plane end: the rest of it is skipped.
    rows.push_back(b_row(8'h05));
    rows.push_back(b_row(8'h11));
    rows.push_back(b_row(8'h22));
    rows.push_back(b_row(8'h33));
    rows.push_back(w_row(8'h44, mk_res(8'h44, 8'd1, 2'd0, 1'b1, 1'b1, 1'b1)));
    rows.push_back(b_row(8'h00));
    rows.push_back(b_row(8'hff));
    // A repeat run clipped to the space left in the plane.
    rows.push_back(b_row(8'hff));
    rows.push_back(w_row(8'h3c, mk_res(8'h3c, 8'd4, 2'd0, 1'b1, 1'b1, 1'b1)));
    // Zero plane size and zero plane count both act as one.
    rows.push_back(c_row(CFG_PLANE_BYTES, 13'd0));
    rows.push_back(c_row(CFG_PLANE_COUNT, 13'd0));
    rows.push_back(b_row(8'h81));
    rows.push_back(w_row(8'h01, mk_res(8'h01, 8'd1, 2'd0, 1'b1, 1'b1, 1'b1)));
    // Oversized plane is clamped to the maximum.
    rows.push_back(c_row(CFG_PLANE_BYTES, 13'h1fff));
    rows.push_back(c_row(CFG_PLANE_COUNT, 13'd2));
    rows.push_back(b_row(8'h00));
    rows.push_back(b_row(8'h80));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) cfg_write(rows[i].reg_sel, rows[i].data);
      else send_byte(rows[i].data[7:0], rows[i].typed, rows[i].want);
    end

    // Random phases: new settings, then mostly well-formed runs with some noise.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) size_val = 13'd0;
      else if (sel < 15) size_val = CFG_DATA_W'(MAX_PLANE_BYTES);
      else if (sel < 20) size_val = CFG_DATA_W'($urandom_range(MAX_PLANE_BYTES + 1, 8191));
      else if (sel < 50) size_val = CFG_DATA_W'($urandom_range(1, 8));
      else if (sel < 85) size_val = CFG_DATA_W'($urandom_range(9, 64));
      else size_val = CFG_DATA_W'($urandom_range(65, 600));
      count_val       = CFG_DATA_W'($urandom_range(0, 8191));
      count_val[1:0]  = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 3);
      if (sel != 1) cfg_write(CFG_PLANE_BYTES, size_val);
      if (sel != 2) cfg_write(CFG_PLANE_COUNT, count_val);
      long_runs = (plane_size() > 600);
      phase_len   = long_runs ? 120 : int'($urandom_range(20, 80));
      phase_start = items_sent;
      while (items_sent - phase_start < phase_len) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
          send_byte(n[7:0], 1'b0, '0);
          repeat (n + 1) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (sel < 85) begin
          send_byte(long_runs ? 8'hff : 8'($urandom_range(128, 255)), 1'b0, '0);
          send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end

    drain();
    if (pending_pixels.size() != 0)
      flag_mismatch("results still expected", 0, pending_pixels.size());
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
